// ===== rtl/scsa_pkg.sv =====
// Shared types and constants of the size-class slot allocator.
`timescale 1ns / 1ps

package scsa_pkg;

  // Field widths of the request and result items.
  localparam int BYTE_W  = 24;
  localparam int GRANT_W = 32;
  localparam int STAT_W  = GRANT_W + BYTE_W;
  localparam int HCLS_W  = 3;
  localparam int HSLOT_W = 4;
  localparam int CMD_W   = 2;
  localparam int STS_W   = 3;

  // Configuration port: six class size registers at byte address 4*i.
  localparam int NUM_REGS = 6;
  localparam int REG_IDX_W = 3;
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  localparam logic [BYTE_W-1:0] SIZE_RESET [NUM_REGS] = '{
    24'd1024, 24'd65536, 24'd262144, 24'd1048576, 24'd4194304, 24'd8388608
  };

  // Last register, also used by every class beyond the register list.
  localparam logic [REG_IDX_W-1:0] LAST_REG = REG_IDX_W'(NUM_REGS - 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_RESIZE  = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [STS_W-1:0] {
    STS_GRANT      = 3'd0,
    STS_HEAP       = 3'd1,
    STS_RELEASED   = 3'd2,
    STS_NOT_POOLED = 3'd3,
    STS_KEPT       = 3'd4
  } status_t;

endpackage

// ===== rtl/scsa_req_if.sv =====
// Request channel of the allocator: command and handle.
`timescale 1ns / 1ps

interface scsa_req_if;
  import scsa_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic [BYTE_W-1:0]       request_bytes;
  logic                    handle_pooled;
  logic [HCLS_W-1:0]       handle_class;
  logic [HSLOT_W-1:0]      handle_slot;

  modport source (
    output valid, command, request_bytes, handle_pooled, handle_class, handle_slot,
    input  ready
  );

  modport sink (
    input  valid, command, request_bytes, handle_pooled, handle_class, handle_slot,
    output ready
  );
endinterface

// ===== rtl/scsa_rsp_if.sv =====
// Result channel of the allocator: status, handle and slot statistics.
`timescale 1ns / 1ps

interface scsa_rsp_if;
  import scsa_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [STS_W-1:0]        status;
  logic                    out_pooled;
  logic [HCLS_W-1:0]       out_class;
  logic [HSLOT_W-1:0]      out_slot;
  logic [GRANT_W-1:0]      out_use_count;
  logic [BYTE_W-1:0]       out_max_usage;

  modport source (
    output valid, status, out_pooled, out_class, out_slot, out_use_count, out_max_usage,
    input  ready
  );

  modport sink (
    input  valid, status, out_pooled, out_class, out_slot, out_use_count, out_max_usage,
    output ready
  );
endinterface

// ===== rtl/scsa_stat_mem.sv =====
// Per-slot statistics memory: grant count and peak request, registered read.
`timescale 1ns / 1ps

module scsa_stat_mem #(
  parameter int DEPTH  = 96,
  parameter int ADDR_W = 7
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [ADDR_W-1:0]           waddr,
  input  logic [scsa_pkg::STAT_W-1:0] wdata,
  input  logic [ADDR_W-1:0]           raddr,
  output logic [scsa_pkg::STAT_W-1:0] rdata
);
  import scsa_pkg::*;

  logic [STAT_W-1:0] mem [DEPTH];

  // One write port and one read port, read data registered.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/size_class_slot_allocator_top.sv =====
// Size-class slot allocator: a sequencer around one shared 24-bit comparator.
// An allocation scans the classes, then the slots of the chosen class, then reads and updates
// the statistics; a pooled resize checks its class first, then keeps the slot or moves like
// an allocation; a release or keep reads the statistics; a heap-handle release goes straight
// to the finish; a heap fallback ends after the class or slot scan. A full output register
// holds the finish. One request at a time, the next accepted in the cycle after a result is
// registered. Reset clears the busy map, then zeroes the statistics before any request.
`timescale 1ns / 1ps

module size_class_slot_allocator_top #(
  parameter int NUM_CLASSES     = 6,
  parameter int SLOTS_PER_CLASS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [scsa_pkg::PADDR_W-1:0] paddr,
  input  logic [scsa_pkg::PDATA_W-1:0] pwdata,
  output logic [scsa_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  scsa_req_if.sink                     req,
  scsa_rsp_if.source                   rsp
);
  import scsa_pkg::*;

  localparam int TOTAL  = NUM_CLASSES * SLOTS_PER_CLASS;
  localparam int ADDR_W = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int CLS_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int SLOT_W = (SLOTS_PER_CLASS > 1) ? $clog2(SLOTS_PER_CLASS) : 1;

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_CHECK  = 8'b0000_0100,
    S_CLASS  = 8'b0000_1000,
    S_SLOT   = 8'b0001_0000,
    S_READ   = 8'b0010_0000,
    S_UPDATE = 8'b0100_0000,
    S_FINISH = 8'b1000_0000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [BYTE_W-1:0]    class_size [NUM_REGS];
  logic [REG_IDX_W-1:0] cfg_idx;
  logic                 cfg_wr;

  // Latched request.
  cmd_t               cmd_in;
  logic [BYTE_W-1:0]  bytes_q;
  logic [HCLS_W-1:0]  hcls_q;
  logic [HSLOT_W-1:0] hslot_q;
  logic [ADDR_W-1:0]  old_idx;
  logic               release_pending;
  logic               write_stats;

  // Scan counters and busy map.
  logic [CLS_W-1:0]   cls_cnt;
  logic [SLOT_W-1:0]  slot_cnt;
  logic [ADDR_W-1:0]  scan_idx;
  logic [ADDR_W-1:0]  clr_cnt;
  logic [TOTAL-1:0]   busy;

  // Request decode.
  logic               accept;
  logic               in_pooled;
  logic [ADDR_W-1:0]  in_idx;

  // Shared comparator.
  logic [HCLS_W-1:0]    class_pick;
  logic [REG_IDX_W-1:0] reg_sel;
  logic [BYTE_W-1:0]    cmp_b;
  logic                 cmp_le;

  // Statistics memory ports.
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [STAT_W-1:0]  mem_wdata;
  logic [ADDR_W-1:0]  rd_addr;
  logic [STAT_W-1:0]  rd_data;
  logic [GRANT_W-1:0] grants_old;
  logic [GRANT_W-1:0] grants_new;
  logic [BYTE_W-1:0]  peak_old;
  logic [BYTE_W-1:0]  peak_new;

  // Result being built, and the output register.
  status_t            res_status;
  logic               res_pooled;
  logic [HCLS_W-1:0]  res_class;
  logic [HSLOT_W-1:0] res_slot;
  logic [GRANT_W-1:0] res_count;
  logic [BYTE_W-1:0]  res_peak;
  logic               out_valid;
  status_t            out_status;
  logic               out_pooled;
  logic [HCLS_W-1:0]  out_class;
  logic [HSLOT_W-1:0] out_slot;
  logic [GRANT_W-1:0] out_count;
  logic [BYTE_W-1:0]  out_peak;

  // APB register port: writes at the access phase, reads return the register.
  assign pready  = 1'b1;
  assign cfg_idx = paddr[PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        class_size[i] <= SIZE_RESET[i];
      end
    end else if (cfg_wr && (cfg_idx < REG_IDX_W'(NUM_REGS))) begin
      class_size[cfg_idx] <= pwdata[BYTE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (cfg_idx < REG_IDX_W'(NUM_REGS)) begin
      prdata = PDATA_W'(class_size[cfg_idx]);
    end
  end

  // Request decode: a handle outside the pool counts as a heap handle.
  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign cmd_in    = cmd_t'(req.command);
  assign in_pooled = req.handle_pooled
                     && ({1'b0, req.handle_class} < 4'(NUM_CLASSES))
                     && ({3'b000, req.handle_slot} < 7'(SLOTS_PER_CLASS));
  assign in_idx    = ADDR_W'(ADDR_W'(req.handle_class) * ADDR_W'(SLOTS_PER_CLASS)
                     + ADDR_W'(req.handle_slot));
  assign scan_idx  = ADDR_W'(ADDR_W'(cls_cnt) * ADDR_W'(SLOTS_PER_CLASS)
                     + ADDR_W'(slot_cnt));

  // Shared comparator: class fit during the scan and keep check, peak during update.
  assign class_pick = (state == S_CLASS) ? HCLS_W'(cls_cnt) : hcls_q;
  assign reg_sel    = (class_pick < HCLS_W'(NUM_REGS)) ? REG_IDX_W'(class_pick) : LAST_REG;
  assign cmp_b      = (state == S_UPDATE) ? peak_old : class_size[reg_sel];
  assign cmp_le     = (bytes_q <= cmp_b);

  // Statistics update for a fresh grant: saturating count, running peak.
  assign grants_old = rd_data[STAT_W-1:BYTE_W];
  assign peak_old   = rd_data[BYTE_W-1:0];
  assign grants_new = (grants_old == '1) ? grants_old : grants_old + GRANT_W'(1);
  assign peak_new   = cmp_le ? peak_old : bytes_q;

  // Memory write: zeroes during the clearing pass, new statistics on a grant.
  assign mem_we    = (state == S_CLEAR) || ((state == S_UPDATE) && write_stats);
  assign mem_waddr = (state == S_CLEAR) ? clr_cnt : rd_addr;
  assign mem_wdata = (state == S_CLEAR) ? '0 : {grants_new, peak_new};

  scsa_stat_mem #(
    .DEPTH  (TOTAL),
    .ADDR_W (ADDR_W)
  ) u_stat_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_CLEAR;
      clr_cnt         <= '0;
      busy            <= '0;
      release_pending <= 1'b0;
      write_stats     <= 1'b0;
      cls_cnt         <= '0;
      slot_cnt        <= '0;
      rd_addr         <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          if (clr_cnt == ADDR_W'(TOTAL - 1)) begin
            state <= S_IDLE;
          end
          clr_cnt <= clr_cnt + ADDR_W'(1);
        end

        S_IDLE: begin
          if (accept) begin
            bytes_q         <= req.request_bytes;
            hcls_q          <= req.handle_class;
            hslot_q         <= req.handle_slot;
            old_idx         <= in_idx;
            release_pending <= 1'b0;
            write_stats     <= 1'b0;
            cls_cnt         <= '0;
            unique case (cmd_in)
              CMD_ALLOC: begin
                state <= S_CLASS;
              end
              CMD_RELEASE: begin
                if (in_pooled) begin
                  busy[in_idx] <= 1'b0;
                  rd_addr      <= in_idx;
                  res_status   <= STS_RELEASED;
                  res_pooled   <= 1'b1;
                  res_class    <= req.handle_class;
                  res_slot     <= req.handle_slot;
                  state        <= S_READ;
                end else begin
                  res_status <= STS_NOT_POOLED;
                  res_pooled <= 1'b0;
                  res_class  <= '0;
                  res_slot   <= '0;
                  res_count  <= '0;
                  res_peak   <= '0;
                  state      <= S_FINISH;
                end
              end
              CMD_RESIZE: begin
                state <= in_pooled ? S_CHECK : S_CLASS;
              end
              CMD_NONE: begin
                state <= S_IDLE;
              end
            endcase
          end
        end

        // Resize of a pooled slot: keep it when its class still covers the size.
        S_CHECK: begin
          if (cmp_le) begin
            rd_addr    <= old_idx;
            res_status <= STS_KEPT;
            res_pooled <= 1'b1;
            res_class  <= hcls_q;
            res_slot   <= hslot_q;
            state      <= S_READ;
          end else begin
            release_pending <= 1'b1;
            state           <= S_CLASS;
          end
        end

        // Lowest-numbered class whose size covers the request, one class a cycle.
        S_CLASS: begin
          if (cmp_le) begin
            slot_cnt <= '0;
            state    <= S_SLOT;
          end else if (cls_cnt == CLS_W'(NUM_CLASSES - 1)) begin
            res_status <= STS_HEAP;
            res_pooled <= 1'b0;
            res_class  <= '0;
            res_slot   <= '0;
            res_count  <= '0;
            res_peak   <= '0;
            state      <= S_FINISH;
          end else begin
            cls_cnt <= cls_cnt + CLS_W'(1);
          end
        end

        // Lowest free slot of the chosen class, one slot a cycle.
        S_SLOT: begin
          if (!busy[scan_idx]) begin
            busy[scan_idx] <= 1'b1;
            rd_addr        <= scan_idx;
            write_stats    <= 1'b1;
            res_status     <= STS_GRANT;
            res_pooled     <= 1'b1;
            res_class      <= HCLS_W'(cls_cnt);
            res_slot       <= HSLOT_W'(slot_cnt);
            state          <= S_READ;
          end else if (slot_cnt == SLOT_W'(SLOTS_PER_CLASS - 1)) begin
            res_status <= STS_HEAP;
            res_pooled <= 1'b0;
            res_class  <= '0;
            res_slot   <= '0;
            res_count  <= '0;
            res_peak   <= '0;
            state      <= S_FINISH;
          end else begin
            slot_cnt <= slot_cnt + SLOT_W'(1);
          end
        end

        S_READ: begin
          state <= S_UPDATE;
        end

        // Statistics of the resulting slot, updated on a grant.
        S_UPDATE: begin
          if (write_stats) begin
            res_count <= grants_new;
            res_peak  <= peak_new;
          end else begin
            res_count <= grants_old;
            res_peak  <= peak_old;
          end
          state <= S_FINISH;
        end

        // Hand the result over and free the old slot of a moved resize.
        S_FINISH: begin
          if (!out_valid || rsp.ready) begin
            if (release_pending) begin
              busy[old_idx] <= 1'b0;
            end
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register: loaded from the finished result, held until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_FINISH) && (!out_valid || rsp.ready)) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_FINISH) && (!out_valid || rsp.ready)) begin
      out_status <= res_status;
      out_pooled <= res_pooled;
      out_class  <= res_class;
      out_slot   <= res_slot;
      out_count  <= res_count;
      out_peak   <= res_peak;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.out_pooled    = out_pooled;
  assign rsp.out_class     = out_class;
  assign rsp.out_slot      = out_slot;
  assign rsp.out_use_count = out_count;
  assign rsp.out_max_usage = out_peak;

endmodule

// ===== verif/testbench.sv =====
// Testbench of the size-class slot allocator: directed and random requests against a pool model.
`timescale 1ns / 1ps

module testbench;
  import scsa_pkg::*;

  localparam int N_CLS         = 6;
  localparam int N_SLOT        = 16;
  localparam int N_POOL        = N_CLS * N_SLOT;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS   = 60;
  localparam int RANDOM_CHUNKS = 10;
  localparam int CHUNK_ITEMS   = 105;

  typedef struct packed {
    cmd_t               cmd;
    logic [BYTE_W-1:0]  bytes;
    logic               pooled;
    logic [HCLS_W-1:0]  cls;
    logic [HSLOT_W-1:0] slot;
  } request_t;

  typedef struct packed {
    status_t            status;
    logic               pooled;
    logic [HCLS_W-1:0]  cls;
    logic [HSLOT_W-1:0] slot;
    logic [GRANT_W-1:0] uses;
    logic [BYTE_W-1:0]  peak;
  } result_t;

  typedef logic [NUM_REGS-1:0][BYTE_W-1:0] size_set_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  scsa_req_if req_ch();
  scsa_rsp_if rsp_ch();

  size_class_slot_allocator_top #(
    .NUM_CLASSES    (N_CLS),
    .SLOTS_PER_CLASS(N_SLOT)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .req    (req_ch),
    .rsp    (rsp_ch)
  );

  // Pool model: class capacities and per-slot occupancy and statistics.
  logic [BYTE_W-1:0]  class_size       [NUM_REGS];
  logic               slot_taken       [N_POOL];
  logic [BYTE_W-1:0]  slot_peak_bytes  [N_POOL];
  logic [GRANT_W-1:0] slot_grant_count [N_POOL];

  result_t pending_results[$];
  result_t want;
  int      mismatches = 0;
  bit      req_eager = 1'b0;
  bit      rsp_eager = 1'b0;
  int      rsp_hold_cycles = 0;

  // Clock of 10 ns.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic request_t make_request(cmd_t cmd, logic [BYTE_W-1:0] bytes, logic pooled,
                                            logic [HCLS_W-1:0] cls, logic [HSLOT_W-1:0] slot);
    request_t q;
    q.cmd    = cmd;
    q.bytes  = bytes;
    q.pooled = pooled;
    q.cls    = cls;
    q.slot   = slot;
    return q;
  endfunction

  // Grants the first free slot of the lowest-numbered class that covers the request.
  function automatic result_t grant_from_pool(logic [BYTE_W-1:0] bytes);
    result_t r;
    int      c;
    int      s;
    int      idx;
    r = '0;
    r.status = STS_HEAP;
    c = 0;
    while (c < N_CLS && bytes > class_size[c]) c++;
    if (c == N_CLS) return r;
    for (s = 0; s < N_SLOT; s++) begin
      idx = c * N_SLOT + s;
      if (!slot_taken[idx]) begin
        slot_taken[idx] = 1'b1;
        if (slot_grant_count[idx] != '1) slot_grant_count[idx]++;
        if (bytes > slot_peak_bytes[idx]) slot_peak_bytes[idx] = bytes;
        r.status = STS_GRANT;
        r.pooled = 1'b1;
        r.cls    = HCLS_W'(c);
        r.slot   = HSLOT_W'(s);
        r.uses   = slot_grant_count[idx];
        r.peak   = slot_peak_bytes[idx];
        return r;
      end
    end
    return r;
  endfunction

  // Applies one request to the pool model; returns 0 when the request gives no result.
  function automatic bit allocator_outcome(request_t q, output result_t r);
    bit handle_ok;
    int idx;
    r = '0;
    handle_ok = q.pooled && q.cls < N_CLS && q.slot < N_SLOT;
    idx = handle_ok ? int'(q.cls) * N_SLOT + int'(q.slot) : 0;
    case (q.cmd)
      CMD_ALLOC: begin
        r = grant_from_pool(q.bytes);
      end
      CMD_RELEASE, CMD_RESIZE: begin
        if (q.cmd == CMD_RESIZE && !(handle_ok && class_size[q.cls] >= q.bytes)) begin
          // A move allocates first and frees the old slot afterwards.
          r = grant_from_pool(q.bytes);
          if (handle_ok) slot_taken[idx] = 1'b0;
        end else if (handle_ok) begin
          if (q.cmd == CMD_RELEASE) slot_taken[idx] = 1'b0;
          r.status = (q.cmd == CMD_RELEASE) ? STS_RELEASED : STS_KEPT;
          r.pooled = 1'b1;
          r.cls    = q.cls;
          r.slot   = q.slot;
          r.uses   = slot_grant_count[idx];
          r.peak   = slot_peak_bytes[idx];
        end else begin
          r.status = STS_NOT_POOLED;
        end
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // Byte counts around the class boundaries, plus small and full-range values.
  function automatic logic [BYTE_W-1:0] draw_bytes();
    logic [BYTE_W-1:0] cap;
    cap = class_size[$urandom_range(0, NUM_REGS - 1)];
    case ($urandom_range(0, 5))
      0:       return BYTE_W'($urandom_range(0, 15));
      1:       return cap;
      2:       return cap + 1'b1;
      3:       return cap - 1'b1;
      4:       return BYTE_W'($urandom_range(0, cap));
      default: return BYTE_W'($urandom());
    endcase
  endfunction

  function automatic bit pick_busy_slot(output logic [HCLS_W-1:0] cls,
                                        output logic [HSLOT_W-1:0] slot);
    int start;
    int k;
    int idx;
    cls = '0;
    slot = '0;
    start = $urandom_range(0, N_POOL - 1);
    for (k = 0; k < N_POOL; k++) begin
      idx = (start + k) % N_POOL;
      if (slot_taken[idx]) begin
        cls  = HCLS_W'(idx / N_SLOT);
        slot = HSLOT_W'(idx % N_SLOT);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Mostly allocations and operations on live handles, the rest noise.
  function automatic request_t draw_request();
    request_t           q;
    int                 pick;
    logic [HCLS_W-1:0]  cls;
    logic [HSLOT_W-1:0] slot;
    pick = $urandom_range(0, 99);
    q = make_request(CMD_ALLOC, draw_bytes(), 1'b0, HCLS_W'($urandom()), HSLOT_W'($urandom()));
    if (pick >= 97) begin
      q.cmd = CMD_NONE;
    end else if (pick >= 88) begin
      q.cmd    = cmd_t'($urandom_range(0, 3));
      q.pooled = 1'($urandom_range(0, 1));
    end else if (pick >= 40 && pick_busy_slot(cls, slot)) begin
      q.cmd    = (pick < 70) ? CMD_RELEASE : CMD_RESIZE;
      q.pooled = 1'b1;
      q.cls    = cls;
      q.slot   = slot;
    end
    return q;
  endfunction

  // Offers one request after a random gap; predicts its result once accepted.
  task automatic send_request(request_t q);
    int      gap;
    result_t r;
    gap = req_eager ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.command       <= q.cmd;
    req_ch.request_bytes <= q.bytes;
    req_ch.handle_pooled <= q.pooled;
    req_ch.handle_class  <= q.cls;
    req_ch.handle_slot   <= q.slot;
    do @(posedge clk); while (!req_ch.ready);
    if (allocator_outcome(q, r)) pending_results.push_back(r);
  endtask

  // Stops offering requests and lets the block finish everything in flight.
  task automatic wait_for_idle();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all six class size registers; the upper data bits are don't-care.
  task automatic program_class_sizes(size_set_t sizes);
    int i;
    for (i = 0; i < NUM_REGS; i++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= PADDR_W'(4 * i);
      pwdata  <= {8'($urandom()), sizes[i]};
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      class_size[i] = sizes[i];
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_directed_cases();
    // Class boundaries and oversize requests.
    send_request(make_request(CMD_ALLOC, 24'd0, 1'b0, 3'd0, 4'd0));
    send_request(make_request(CMD_ALLOC, 24'd1024, 1'b1, 3'd7, 4'd15));
    send_request(make_request(CMD_ALLOC, 24'd1025, 1'b0, 3'd0, 4'd0));
    send_request(make_request(CMD_ALLOC, 24'd8388608, 1'b0, 3'd0, 4'd0));
    send_request(make_request(CMD_ALLOC, 24'd8388609, 1'b0, 3'd0, 4'd0));
    send_request(make_request(CMD_ALLOC, 24'hFFFFFF, 1'b0, 3'd0, 4'd0));
    send_request(make_request(CMD_ALLOC, 24'd262144, 1'b0, 3'd0, 4'd0));
    send_request(make_request(CMD_ALLOC, 24'd65537, 1'b0, 3'd0, 4'd0));
    // Release of a busy slot, then of the same slot once free.
    send_request(make_request(CMD_RELEASE, 24'd0, 1'b1, 3'd0, 4'd0));
    send_request(make_request(CMD_RELEASE, 24'hFFFFFF, 1'b1, 3'd0, 4'd0));
    // Heap handles and handles with a class out of range.
    send_request(make_request(CMD_RELEASE, 24'd5, 1'b0, 3'd2, 4'd3));
    send_request(make_request(CMD_RELEASE, 24'd0, 1'b1, 3'd6, 4'd0));
    send_request(make_request(CMD_RELEASE, 24'd0, 1'b1, 3'd7, 4'd15));
    // Resize that keeps, moves, or works on free, heap and invalid handles.
    send_request(make_request(CMD_RESIZE, 24'd60000, 1'b1, 3'd1, 4'd0));
    send_request(make_request(CMD_RESIZE, 24'd5000, 1'b1, 3'd0, 4'd1));
    send_request(make_request(CMD_RESIZE, 24'd100, 1'b1, 3'd2, 4'd9));
    send_request(make_request(CMD_RESIZE, 24'd2000, 1'b1, 3'd0, 4'd3));
    send_request(make_request(CMD_RESIZE, 24'd100, 1'b0, 3'd1, 4'd0));
    send_request(make_request(CMD_RESIZE, 24'hFFFFFF, 1'b0, 3'd0, 4'd0));
    send_request(make_request(CMD_RESIZE, 24'd10, 1'b1, 3'd6, 4'd2));
    send_request(make_request(CMD_RESIZE, 24'hFFFFFF, 1'b1, 3'd5, 4'd0));
    // The unused command code is dropped without a result.
    send_request(make_request(CMD_NONE, 24'h5A5A5A, 1'b1, 3'd1, 4'd1));
    // Reuse of a freed large slot raises its grant count but keeps its higher peak.
    send_request(make_request(CMD_RELEASE, 24'd0, 1'b1, 3'd5, 4'd0));
    send_request(make_request(CMD_ALLOC, 24'd8000000, 1'b0, 3'd0, 4'd0));
    wait_for_idle();
  endtask

  // Fills class zero past its last slot while results are held back.
  task automatic test_pool_exhaustion();
    int i;
    rsp_hold_cycles = 300;
    for (i = 0; i < N_SLOT + 2; i++)
      send_request(make_request(CMD_ALLOC, BYTE_W'($urandom_range(0, 1024)), 1'b0, '0, '0));
    send_request(make_request(CMD_RESIZE, 24'd1, 1'b1, 3'd0, 4'd3));
    for (i = 0; i < N_SLOT; i++)
      send_request(make_request(CMD_RELEASE, BYTE_W'($urandom()), 1'b1, 3'd0, HSLOT_W'(i)));
    wait_for_idle();
  endtask

  // Random traffic under all-zero, all-max, ascending, unordered and reset capacities.
  task automatic test_size_settings();
    size_set_t sizes;
    int        phase;
    int        i;
    int        acc;
    for (phase = 0; phase < 5; phase++) begin
      acc = 0;
      for (i = 0; i < NUM_REGS; i++) begin
        case (phase)
          0: sizes[i] = '0;
          1: sizes[i] = '1;
          2: begin
            acc = acc + $urandom_range(0, 1 << $urandom_range(0, 21));
            if (acc > 24'hFFFFFF) acc = 24'hFFFFFF;
            sizes[i] = BYTE_W'(acc);
          end
          3: sizes[i] = BYTE_W'($urandom());
          default: sizes[i] = SIZE_RESET[i];
        endcase
      end
      program_class_sizes(sizes);
      req_eager = (phase == 1);
      rsp_eager = (phase == 3);
      repeat (PHASE_ITEMS) send_request(draw_request());
      wait_for_idle();
    end
    req_eager = 1'b0;
    rsp_eager = 1'b0;
  endtask

  task automatic test_random_traffic();
    request_t q;
    int       chunk;
    int       n;
    for (chunk = 0; chunk < RANDOM_CHUNKS; chunk++) begin
      req_eager = ($urandom_range(0, 3) == 0);
      rsp_eager = ($urandom_range(0, 3) == 0);
      n = 0;
      while (n < CHUNK_ITEMS) begin
        q = draw_request();
        send_request(q);
        if (q.cmd != CMD_NONE) n++;
      end
    end
    req_eager = 1'b0;
    rsp_eager = 1'b0;
  endtask

  // Result side: random stalls, stretches without stalls and one long hold-off.
  initial begin
    int stall;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = rsp_eager ? 0 : $urandom_range(0, 13);
      if (rsp_hold_cycles > 0) begin
        stall = rsp_hold_cycles;
        rsp_hold_cycles = 0;
      end
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
    end
  end

  task automatic check_field(string what, logic [GRANT_W-1:0] exp_val, logic [GRANT_W-1:0] act);
    if (exp_val !== act) begin
      mismatches++;
      $display("%0t: %s expected %0d, actual %0d", $time, what, exp_val, act);
    end
  endtask

  // Compares each accepted result with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result expected none, actual status %0d class %0d slot %0d", $time,
                 rsp_ch.status, rsp_ch.out_class, rsp_ch.out_slot);
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, rsp_ch.status);
        check_field("out_pooled", want.pooled, rsp_ch.out_pooled);
        check_field("out_class", want.cls, rsp_ch.out_class);
        check_field("out_slot", want.slot, rsp_ch.out_slot);
        check_field("out_use_count", want.uses, rsp_ch.out_use_count);
        check_field("out_max_usage", want.peak, rsp_ch.out_max_usage);
      end
    end
  end

  // Main sequence.
  initial begin
    int i;
    rst                  <= 1'b1;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    req_ch.valid         <= 1'b0;
    req_ch.command       <= CMD_ALLOC;
    req_ch.request_bytes <= '0;
    req_ch.handle_pooled <= 1'b0;
    req_ch.handle_class  <= '0;
    req_ch.handle_slot   <= '0;
    for (i = 0; i < NUM_REGS; i++) class_size[i] = SIZE_RESET[i];
    for (i = 0; i < N_POOL; i++) begin
      slot_taken[i]       = 1'b0;
      slot_peak_bytes[i]  = '0;
      slot_grant_count[i] = '0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_pool_exhaustion();
    test_size_settings();
    test_random_traffic();
    wait_for_idle();

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
